// ----- design/assert_macros.svh -----
// Assertion macros for the design files; the execute top module uses them.
// Depends on nothing; each user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same check but also evaluated while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- design/jise_pkg.sv -----
// Constants and types for the JVM integer stack execute block.
// No dependencies.
package jise_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned TAG_W = 3;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned DIV_STEPS_W = 5;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [ST_W-1:0]  stat_t;
  typedef logic [7:0]       op_t;

  localparam stat_t ST_OK    = 3'd0;
  localparam stat_t ST_UNDER = 3'd1;
  localparam stat_t ST_OVER  = 3'd2;
  localparam stat_t ST_DIV0  = 3'd3;
  localparam stat_t ST_UNSUP = 3'd4;

  localparam tag_t TAG_INT    = 3'd0;
  localparam tag_t TAG_LONG   = 3'd1;
  localparam tag_t TAG_FLOAT  = 3'd2;
  localparam tag_t TAG_DOUBLE = 3'd3;
  localparam tag_t TAG_REF    = 3'd4;
  localparam tag_t TAG_CONST  = 3'd5;
  localparam tag_t TAG_STATIC = 3'd6;

  localparam op_t OP_NOP       = 8'h00;
  localparam op_t OP_ICONST_M1 = 8'h02;
  localparam op_t OP_ICONST_0  = 8'h03;
  localparam op_t OP_ICONST_5  = 8'h08;
  localparam op_t OP_LCONST_0  = 8'h09;
  localparam op_t OP_LCONST_1  = 8'h0A;
  localparam op_t OP_FCONST_0  = 8'h0B;
  localparam op_t OP_FCONST_2  = 8'h0D;
  localparam op_t OP_DCONST_0  = 8'h0E;
  localparam op_t OP_DCONST_1  = 8'h0F;
  localparam op_t OP_BIPUSH    = 8'h10;
  localparam op_t OP_SIPUSH    = 8'h11;
  localparam op_t OP_LDC       = 8'h12;
  localparam op_t OP_ILOAD_0   = 8'h1A;
  localparam op_t OP_DLOAD_3   = 8'h29;
  localparam op_t OP_ALOAD_0   = 8'h2A;
  localparam op_t OP_ISTORE_0  = 8'h3B;
  localparam op_t OP_ISTORE_3  = 8'h3E;
  localparam op_t OP_POP       = 8'h57;
  localparam op_t OP_POP2      = 8'h58;
  localparam op_t OP_IADD      = 8'h60;
  localparam op_t OP_ISUB      = 8'h64;
  localparam op_t OP_IMUL      = 8'h68;
  localparam op_t OP_IDIV      = 8'h6C;
  localparam op_t OP_IREM      = 8'h70;
  localparam op_t OP_IINC      = 8'h84;
  localparam op_t OP_IFEQ      = 8'h99;
  localparam op_t OP_IFLE      = 8'h9E;
  localparam op_t OP_IF_ICMPEQ = 8'h9F;
  localparam op_t OP_IF_ICMPLE = 8'hA4;
  localparam op_t OP_GOTO      = 8'hA7;
  localparam op_t OP_RETURN    = 8'hB1;
  localparam op_t OP_GETSTATIC = 8'hB2;

  localparam logic [2:0] CC_EQ = 3'd0;
  localparam logic [2:0] CC_NE = 3'd1;
  localparam logic [2:0] CC_LT = 3'd2;
  localparam logic [2:0] CC_GE = 3'd3;
  localparam logic [2:0] CC_GT = 3'd4;

  function automatic logic cond_true(logic [2:0] cc, val_t a, val_t b);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    case (cc)
      CC_EQ:   cond_true = (a == b);
      CC_NE:   cond_true = (a != b);
      CC_LT:   cond_true = lt;
      CC_GE:   cond_true = !lt;
      CC_GT:   cond_true = gt;
      default: cond_true = !gt;
    endcase
  endfunction

endpackage

// ----- design/jise_in_if.sv -----
// Bytecode input channel: valid/ready with opcode and operands.
// Depends on jise_pkg.
interface jise_in_if;
  logic                   valid;
  logic                   ready;
  jise_pkg::op_t          op;
  logic signed [15:0]     operand;
  logic signed [7:0]      increment;

  modport source (output valid, output op, output operand, output increment, input ready);
  modport sink   (input valid, input op, input operand, input increment, output ready);
endinterface

// ----- design/jise_out_if.sv -----
// Result channel: valid/ready with branch outcome and stack status.
// Depends on jise_pkg.
interface jise_out_if;
  logic                   valid;
  logic                   ready;
  logic                   branch_taken;
  logic signed [15:0]     branch_offset;
  logic signed [31:0]     top_value;
  jise_pkg::tag_t         top_tag;
  logic [4:0]             stack_depth;
  jise_pkg::stat_t        status;

  modport source (output valid, output branch_taken, output branch_offset, output top_value,
                  output top_tag, output stack_depth, output status, input ready);
  modport sink   (input valid, input branch_taken, input branch_offset, input top_value,
                  input top_tag, input stack_depth, input status, output ready);
endinterface

// ----- design/jvm_int_stack_execute_top.sv -----
// An input transfer registers the opcode, two stack entries and a local slot; the bytecode then
// executes and writes back as its result is registered, once the output is free. idiv and irem
// first run the shared divider, one quotient bit a cycle. New bytecodes are taken only when idle.
// Reset: synchronous active-low rst_n empties the stack and marks all locals as zero.
// Stack top is cached in registers; the memory serves the second and third entries.
// Depends on jise_pkg, jise_in_if, jise_out_if and assert_macros.svh.
`include "assert_macros.svh"
module jvm_int_stack_execute_top #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned LOCAL_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  jise_in_if.sink    in_ch,
  jise_out_if.source out_ch
);

  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned LW = $clog2(LOCAL_COUNT);
  localparam int unsigned EW = jise_pkg::VAL_W + jise_pkg::TAG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SW-1:0]        sp_r, sp_nxt;
  jise_pkg::val_t       tval_r, tval_nxt;
  jise_pkg::tag_t       ttag_r, ttag_nxt;

  jise_pkg::op_t        op_r;
  logic [15:0]          opnd_r;
  logic [7:0]           inc_r;

  logic [EW-1:0]        stk_mem [STACK_DEPTH];
  logic [EW-1:0]        rd1_q, rd2_q;
  logic [EW-1:0]        loc_mem [LOCAL_COUNT];
  logic [LOCAL_COUNT-1:0] lvld_r;
  logic [EW-1:0]        loc_q;
  logic                 lvq;
  logic [LW-1:0]        laddr;

  logic                 out_valid_r;
  logic                 taken_r;
  logic [15:0]          boff_r;
  jise_pkg::val_t       oval_r;
  jise_pkg::tag_t       otag_r;
  logic [4:0]           odep_r;
  jise_pkg::stat_t      ostat_r;

  // divider
  jise_pkg::val_t       quo_r, rem_r, dvs_r;
  logic [jise_pkg::DIV_STEPS_W-1:0] cnt_r;
  logic                 negq_r, negr_r, isrem_r;
  logic [32:0]          trial;
  jise_pkg::val_t       div_res;

  logic                 accept, out_free, commit, div_go;
  jise_pkg::stat_t      st;
  logic                 taken;
  logic                 swe, lwe;
  logic [AW-1:0]        swa;
  logic [EW-1:0]        swd, lwd;
  logic [LW-1:0]        lwa;
  jise_pkg::val_t       a_v, b_v, l_v, pv, arith;
  jise_pkg::tag_t       pt;
  logic                 push_req;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.branch_taken  = taken_r;
  assign out_ch.branch_offset = boff_r;
  assign out_ch.top_value     = oval_r;
  assign out_ch.top_tag       = otag_r;
  assign out_ch.stack_depth   = odep_r;
  assign out_ch.status        = ostat_r;

  // Local read address: iinc index or load slot 0..3
  always_comb begin
    if (in_ch.op == jise_pkg::OP_IINC) laddr = LW'(in_ch.operand);
    else laddr = LW'(2'(in_ch.op - jise_pkg::OP_ILOAD_0));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      opnd_r <= in_ch.operand;
      inc_r  <= in_ch.increment;
      rd1_q  <= stk_mem[AW'(sp_r - SW'(2))];
      rd2_q  <= stk_mem[AW'(sp_r - SW'(3))];
      loc_q  <= loc_mem[laddr];
      lvq    <= lvld_r[laddr];
    end
    if (swe) stk_mem[swa] <= swd;
    if (lwe) loc_mem[lwa] <= lwd;
  end

  assign b_v = tval_r;
  assign a_v = rd1_q[jise_pkg::VAL_W-1:0];
  assign l_v = lvq ? loc_q[jise_pkg::VAL_W-1:0] : '0;

  always_comb begin
    case (op_r)
      jise_pkg::OP_IADD: arith = a_v + b_v;
      jise_pkg::OP_ISUB: arith = a_v - b_v;
      default:           arith = a_v * b_v;
    endcase
  end

  assign trial   = {rem_r, quo_r[31]} - {1'b0, dvs_r};
  assign div_res = isrem_r ? (negr_r ? -rem_r : rem_r) : (negq_r ? -quo_r : quo_r);

  always_comb begin
    st       = jise_pkg::ST_OK;
    taken    = 1'b0;
    sp_nxt   = sp_r;
    tval_nxt = tval_r;
    ttag_nxt = ttag_r;
    swe      = 1'b0;
    swa      = AW'(sp_r);
    swd      = '0;
    lwe      = 1'b0;
    lwa      = LW'(2'(op_r - jise_pkg::OP_ISTORE_0));
    lwd      = {ttag_r, tval_r};
    div_go   = 1'b0;
    push_req = 1'b0;
    pv       = '0;
    pt       = jise_pkg::TAG_INT;
    if (state_r == S_FIN) begin
      sp_nxt   = sp_r - SW'(1);
      swe      = 1'b1;
      swa      = AW'(sp_r - SW'(2));
      swd      = {jise_pkg::TAG_INT, div_res};
      tval_nxt = div_res;
      ttag_nxt = jise_pkg::TAG_INT;
    end else begin
      if (op_r == jise_pkg::OP_NOP || op_r == jise_pkg::OP_RETURN) begin
      end else if (op_r >= jise_pkg::OP_ICONST_M1 && op_r <= jise_pkg::OP_ICONST_5) begin
        push_req = 1'b1;
        pv = jise_pkg::val_t'($signed({1'b0, op_r}) - 9'sd3);
      end else if (op_r == jise_pkg::OP_LCONST_0 || op_r == jise_pkg::OP_LCONST_1) begin
        push_req = 1'b1;
        pv = 32'(op_r - jise_pkg::OP_LCONST_0);
        pt = jise_pkg::TAG_LONG;
      end else if (op_r >= jise_pkg::OP_FCONST_0 && op_r <= jise_pkg::OP_FCONST_2) begin
        push_req = 1'b1;
        pv = 32'(op_r - jise_pkg::OP_FCONST_0);
        pt = jise_pkg::TAG_FLOAT;
      end else if (op_r == jise_pkg::OP_DCONST_0 || op_r == jise_pkg::OP_DCONST_1) begin
        push_req = 1'b1;
        pv = 32'(op_r - jise_pkg::OP_DCONST_0);
        pt = jise_pkg::TAG_DOUBLE;
      end else if (op_r == jise_pkg::OP_BIPUSH || op_r == jise_pkg::OP_SIPUSH ||
                   op_r == jise_pkg::OP_LDC || op_r == jise_pkg::OP_GETSTATIC) begin
        push_req = 1'b1;
        pv = {{16{opnd_r[15]}}, opnd_r};
        if (op_r == jise_pkg::OP_LDC) pt = jise_pkg::TAG_CONST;
        else if (op_r == jise_pkg::OP_GETSTATIC) pt = jise_pkg::TAG_STATIC;
      end else if (op_r >= jise_pkg::OP_ILOAD_0 && op_r <= jise_pkg::OP_DLOAD_3) begin
        push_req = 1'b1;
        pv = l_v;
        pt = jise_pkg::tag_t'(4'(op_r - jise_pkg::OP_ILOAD_0) >> 2);
      end else if (op_r == jise_pkg::OP_ALOAD_0) begin
        push_req = 1'b1;
        pv = l_v;
        pt = jise_pkg::TAG_REF;
      end else if (op_r >= jise_pkg::OP_ISTORE_0 && op_r <= jise_pkg::OP_ISTORE_3) begin
        if (sp_r < SW'(1)) st = jise_pkg::ST_UNDER;
        else begin
          lwe      = 1'b1;
          sp_nxt   = sp_r - SW'(1);
          tval_nxt = rd1_q[jise_pkg::VAL_W-1:0];
          ttag_nxt = rd1_q[EW-1 -: jise_pkg::TAG_W];
        end
      end else if (op_r == jise_pkg::OP_POP) begin
        if (sp_r < SW'(1)) st = jise_pkg::ST_UNDER;
        else begin
          sp_nxt   = sp_r - SW'(1);
          tval_nxt = rd1_q[jise_pkg::VAL_W-1:0];
          ttag_nxt = rd1_q[EW-1 -: jise_pkg::TAG_W];
        end
      end else if (op_r == jise_pkg::OP_POP2) begin
        if (sp_r < SW'(2)) st = jise_pkg::ST_UNDER;
        else begin
          sp_nxt   = sp_r - SW'(2);
          tval_nxt = rd2_q[jise_pkg::VAL_W-1:0];
          ttag_nxt = rd2_q[EW-1 -: jise_pkg::TAG_W];
        end
      end else if (op_r == jise_pkg::OP_IADD || op_r == jise_pkg::OP_ISUB ||
                   op_r == jise_pkg::OP_IMUL) begin
        if (sp_r < SW'(2)) st = jise_pkg::ST_UNDER;
        else begin
          sp_nxt   = sp_r - SW'(1);
          swe      = 1'b1;
          swa      = AW'(sp_r - SW'(2));
          swd      = {jise_pkg::TAG_INT, arith};
          tval_nxt = arith;
          ttag_nxt = jise_pkg::TAG_INT;
        end
      end else if (op_r == jise_pkg::OP_IDIV || op_r == jise_pkg::OP_IREM) begin
        if (sp_r < SW'(2)) st = jise_pkg::ST_UNDER;
        else if (b_v == '0) st = jise_pkg::ST_DIV0;
        else div_go = (state_r == S_EXEC);
      end else if (op_r == jise_pkg::OP_IINC) begin
        lwe = (opnd_r < 16'(LOCAL_COUNT));
        lwa = LW'(opnd_r);
        lwd = {(lvq ? loc_q[EW-1 -: jise_pkg::TAG_W] : jise_pkg::TAG_INT),
               l_v + {{24{inc_r[7]}}, inc_r}};
      end else if (op_r >= jise_pkg::OP_IFEQ && op_r <= jise_pkg::OP_IFLE) begin
        if (sp_r < SW'(1)) st = jise_pkg::ST_UNDER;
        else begin
          taken    = jise_pkg::cond_true(3'(op_r - jise_pkg::OP_IFEQ), b_v, '0);
          sp_nxt   = sp_r - SW'(1);
          tval_nxt = rd1_q[jise_pkg::VAL_W-1:0];
          ttag_nxt = rd1_q[EW-1 -: jise_pkg::TAG_W];
        end
      end else if (op_r >= jise_pkg::OP_IF_ICMPEQ && op_r <= jise_pkg::OP_IF_ICMPLE) begin
        if (sp_r < SW'(2)) st = jise_pkg::ST_UNDER;
        else begin
          taken    = jise_pkg::cond_true(3'(op_r - jise_pkg::OP_IF_ICMPEQ), a_v, b_v);
          sp_nxt   = sp_r - SW'(2);
          tval_nxt = rd2_q[jise_pkg::VAL_W-1:0];
          ttag_nxt = rd2_q[EW-1 -: jise_pkg::TAG_W];
        end
      end else if (op_r == jise_pkg::OP_GOTO) begin
        taken = 1'b1;
      end else begin
        st = jise_pkg::ST_UNSUP;
      end
      if (push_req) begin
        if (sp_r >= SW'(STACK_DEPTH)) st = jise_pkg::ST_OVER;
        else begin
          swe      = 1'b1;
          swa      = AW'(sp_r);
          swd      = {pt, pv};
          sp_nxt   = sp_r + SW'(1);
          tval_nxt = pv;
          ttag_nxt = pt;
        end
      end
    end
    // Only commit side effects on the cycle the result is registered.
    if (!commit) begin
      swe = 1'b0;
      lwe = 1'b0;
    end
  end

  assign commit = ((state_r == S_EXEC && !div_go) || state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (div_go) state_nxt = S_DIV;
        else if (commit) state_nxt = S_IDLE;
      end
      S_DIV:  if (cnt_r == '0) state_nxt = S_FIN;
      S_FIN:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      lvld_r      <= '0;
      tval_r      <= '0;
      ttag_r      <= jise_pkg::TAG_INT;
    end else begin
      state_r <= state_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (commit) begin
        sp_r        <= sp_nxt;
        tval_r      <= tval_nxt;
        ttag_r      <= ttag_nxt;
      end
      if (lwe) lvld_r[lwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      taken_r <= taken;
      boff_r  <= taken ? opnd_r : '0;
      oval_r  <= (sp_nxt == '0) ? '0 : tval_nxt;
      otag_r  <= (sp_nxt == '0) ? jise_pkg::TAG_INT : ttag_nxt;
      odep_r  <= 5'(sp_nxt);
      ostat_r <= st;
    end
  end

  // Restoring divider on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (div_go) begin
      quo_r   <= a_v[31] ? -a_v : a_v;
      dvs_r   <= b_v[31] ? -b_v : b_v;
      rem_r   <= '0;
      cnt_r   <= '1;
      negq_r  <= a_v[31] ^ b_v[31];
      negr_r  <= a_v[31];
      isrem_r <= (op_r == jise_pkg::OP_IREM);
    end else if (state_r == S_DIV) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], quo_r[31]};
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  `ASSERT_CLK(a_accept_exec, accept |=> (state_r == S_EXEC), "transfer did not start execution")
  `ASSERT_CLK(a_sp_range, sp_r <= SW'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_CLK(a_over_hold, (commit && st == jise_pkg::ST_OVER) |=> $stable(sp_r), "overflow moved sp")
  `ASSERT_CLK(a_div_wait, (state_r == S_DIV) |-> !out_valid_r || !$rose(out_valid_r), "result during divide")

endmodule
